### sv/rgbc_pkg.sv
package rgbc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int WID_W      = 11;
	localparam int HGT_W      = 13;
	localparam int PIX_W      = 24;
	localparam int COEF_W     = 16;
	localparam int DIV_W      = 16;
	localparam int PROD_W     = 25;
	localparam int SUM_W      = 28;
	localparam int DIVD_W     = 27;
	localparam int KROW_W     = 48;
	localparam int Q_DEPTH    = 2;
	localparam int Q_AW       = 1;
	localparam int PIX_MAX    = 255;

	localparam logic [2:0] REG_WIDTH   = 3'd0;
	localparam logic [2:0] REG_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_DIVISOR = 3'd2;
	localparam logic [2:0] REG_KTOP    = 3'd3;
	localparam logic [2:0] REG_KMID    = 3'd4;
	localparam logic [2:0] REG_KBOT    = 3'd5;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       frame_start;
	} pixel_t;

	typedef struct packed {
		logic [7:0]       red_out;
		logic [7:0]       green_out;
		logic [7:0]       blue_out;
		logic [ROW_W-1:0] centre_row;
		logic [COL_W-1:0] centre_col;
		logic             frame_done;
	} result_t;

	typedef struct packed {
		logic [WID_W-1:0] width;
		logic [HGT_W-1:0] height;
	} geom_t;

	typedef struct packed {
		logic [DIV_W-1:0]             divisor;
		logic [2:0][KROW_W-1:0]       kernel;
	} coef_t;

	// window[row][col], col 2 newest; pixel packs red in bits 7:0
	typedef struct packed {
		logic [2:0][2:0][PIX_W-1:0] win;
		logic [ROW_W-1:0]           row;
		logic [COL_W-1:0]           col;
		logic                       done;
	} job_t;

endpackage

### sv/rgbc_ram.sv
module rgbc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/rgbc_queue.sv
module rgbc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rgbc_pkg::job_t din,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output rgbc_pkg::job_t dout
);
	import rgbc_pkg::*;

	job_t            slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q, rptr_q;
	logic [Q_AW:0]   cnt_q;

	assign full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_AW+1)'(push && !full) - (Q_AW+1)'(pop && !empty);
		end
	end

endmodule

### sv/rgbc_front.sv
module rgbc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  rgbc_pkg::geom_t geom,
	input  logic            push,
	input  rgbc_pkg::pixel_t pixel_in,
	output logic            full,
	input  logic            q_full,
	output logic            job_push,
	output rgbc_pkg::job_t  job
);
	import rgbc_pkg::*;

	logic                     phase_q;
	logic [ROW_W-1:0]         row_q, r_s1;
	logic [COL_W-1:0]         col_q, c_s1;
	logic [PIX_W-1:0]         pix_s1;
	logic [2:0][2:0][PIX_W-1:0] win_q, win_nxt;
	logic [PIX_W-1:0]         top_rd, mid_rd;
	logic                     accept;
	logic [ROW_W-1:0]         cur_r;
	logic [COL_W-1:0]         cur_c;
	logic [WID_W-1:0]         w_eff;
	logic [HGT_W-1:0]         h_eff;
	logic [WID_W-1:0]         c_inc;
	logic [HGT_W-1:0]         r_inc;

	assign full   = phase_q | q_full;
	assign accept = push && !full;
	assign cur_r  = pixel_in.frame_start ? '0 : row_q;
	assign cur_c  = pixel_in.frame_start ? '0 : col_q;

	always_comb begin
		w_eff = geom.width;
		if (geom.width < WID_W'(3)) w_eff = WID_W'(3);
		if (geom.width > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
		h_eff = geom.height;
		if (geom.height < HGT_W'(3)) h_eff = HGT_W'(3);
		if (geom.height > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
	end

	// row r-2 in one store, row r-1 in the other
	rgbc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top (
		.clk(clk), .we(phase_q), .waddr(c_s1), .wdata(mid_rd),
		.re(accept), .raddr(cur_c), .rdata(top_rd)
	);

	rgbc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid (
		.clk(clk), .we(phase_q), .waddr(c_s1), .wdata(pix_s1),
		.re(accept), .raddr(cur_c), .rdata(mid_rd)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_nxt[k][0] = win_q[k][1];
			win_nxt[k][1] = win_q[k][2];
		end
		win_nxt[0][2] = top_rd;
		win_nxt[1][2] = mid_rd;
		win_nxt[2][2] = pix_s1;
	end

	assign job_push = phase_q && (r_s1 >= ROW_W'(2)) && (c_s1 >= COL_W'(2))
		&& ({1'b0, r_s1} < h_eff) && ({1'b0, c_s1} < w_eff);
	assign job.win  = win_nxt;
	assign job.row  = r_s1 - ROW_W'(1);
	assign job.col  = c_s1 - COL_W'(1);
	assign job.done = ({1'b0, r_s1} == h_eff - HGT_W'(1))
		&& ({1'b0, c_s1} == w_eff - WID_W'(1));

	assign c_inc = {1'b0, c_s1} + WID_W'(1);
	assign r_inc = {1'b0, r_s1} + HGT_W'(1);

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= {pixel_in.blue_in, pixel_in.green_in, pixel_in.red_in};
			r_s1   <= cur_r;
			c_s1   <= cur_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			win_q   <= '0;
		end else begin
			if (accept) begin
				phase_q <= 1'b1;
			end else if (phase_q) begin
				phase_q <= 1'b0;
				win_q   <= win_nxt;
				if (c_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
				end else begin
					col_q <= c_inc[COL_W-1:0];
					row_q <= r_s1;
				end
			end
		end
	end

endmodule

### sv/rgbc_back.sv
module rgbc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rgbc_pkg::coef_t  coefs,
	input  logic             q_empty,
	input  rgbc_pkg::job_t   q_job,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output rgbc_pkg::result_t result
);
	import rgbc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MAC  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]              state_q;
	job_t                    job_q;
	logic [1:0]              krow_q, kcol_q;
	logic [4:0]              step_q;
	logic signed [SUM_W-1:0] acc_q   [3];
	logic signed [SUM_W-1:0] acc_nxt [3];
	logic [DIVD_W-1:0]       quo_q   [3];
	logic [DIV_W-1:0]        rem_q   [3];
	logic [DIVD_W-1:0]       quo_nxt [3];
	logic [DIV_W-1:0]        rem_nxt [3];
	logic signed [PROD_W-1:0] prod   [3];
	logic signed [COEF_W-1:0] coef;
	logic [DIV_W-1:0]        dvs;
	logic                    res_valid_q;
	result_t                 res_q;
	logic [7:0]              clamp   [3];
	logic                    load_res;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign load_res = (state_q == ST_DONE) && (!res_valid_q || pop);
	assign empty    = !res_valid_q;
	assign result   = res_q;
	assign dvs      = (coefs.divisor == '0) ? DIV_W'(1) : coefs.divisor;
	assign coef     = coefs.kernel[krow_q][kcol_q*COEF_W +: COEF_W];

	always_comb begin
		logic [DIV_W:0] trial;
		for (int p = 0; p < 3; p++) begin
			prod[p] = $signed({1'b0, job_q.win[krow_q][kcol_q][p*8 +: 8]}) * coef;
			acc_nxt[p] = acc_q[p] + SUM_W'(prod[p]);
			trial = {rem_q[p], quo_q[p][DIVD_W-1]};
			if (trial >= {1'b0, dvs}) begin
				rem_nxt[p] = DIV_W'(trial - {1'b0, dvs});
				quo_nxt[p] = {quo_q[p][DIVD_W-2:0], 1'b1};
			end else begin
				rem_nxt[p] = trial[DIV_W-1:0];
				quo_nxt[p] = {quo_q[p][DIVD_W-2:0], 1'b0};
			end
			clamp[p] = (quo_q[p] > DIVD_W'(PIX_MAX)) ? 8'(PIX_MAX) : quo_q[p][7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		case (state_q)
			ST_IDLE: begin
				for (int p = 0; p < 3; p++) acc_q[p] <= '0;
			end
			ST_MAC: begin
				for (int p = 0; p < 3; p++) begin
					acc_q[p] <= acc_nxt[p];
					// a sum at or below zero truncates to a clamped zero
					quo_q[p] <= (acc_nxt[p] > 0) ? acc_nxt[p][DIVD_W-1:0] : '0;
					rem_q[p] <= '0;
				end
			end
			ST_DIV: begin
				if (step_q != 5'(DIVD_W)) begin
					for (int p = 0; p < 3; p++) begin
						quo_q[p] <= quo_nxt[p];
						rem_q[p] <= rem_nxt[p];
					end
				end
			end
			default: begin
			end
		endcase
		if (load_res) begin
			res_q.red_out    <= clamp[0];
			res_q.green_out  <= clamp[1];
			res_q.blue_out   <= clamp[2];
			res_q.centre_row <= job_q.row;
			res_q.centre_col <= job_q.col;
			res_q.frame_done <= job_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			krow_q      <= '0;
			kcol_q      <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_MAC;
						krow_q  <= '0;
						kcol_q  <= '0;
					end
				end
				ST_MAC: begin
					if (kcol_q == 2'd2) begin
						kcol_q <= '0;
						if (krow_q == 2'd2) begin
							state_q <= ST_DIV;
							step_q  <= '0;
						end else begin
							krow_q <= krow_q + 2'd1;
						end
					end else begin
						kcol_q <= kcol_q + 2'd1;
					end
				end
				ST_DIV: begin
					if (step_q == 5'(DIVD_W)) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_DONE: begin
					if (load_res) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !pop |=> res_valid_q && $stable(res_q))
		else $error("result dropped while stalled");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_MAC && krow_q == 2'd0 && kcol_q == 2'd0)
		else $error("job taken outside idle");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded before division finished");

endmodule

### sv/rgb_3x3_convolution_clamp_top.sv
// RGB 3x3 convolution with divisor and clamp to 0..255.
// Input: pixels in raster order on pixel_in; taken when push is high and full low.
// frame_start on a pixel puts it at row 0, column 0. Border pixels give no result.
// Output: result holds the oldest result while empty is low; pop takes it.
// Configuration: cfg_index/cfg_data written when cfg_valid and cfg_ready are high
// (cfg_ready is always high); write only while the block is idle.
// Front: a pixel is handled as a line store read, then write-back and window shift,
// and no new pixel is taken until that is done, nor while the job queue is full.
// Back: takes a job, then multiply-accumulates over the nine taps (three planes at
// once, one tap a cycle), then runs restoring division (27 quotient bits, one a
// cycle, then a last step to finish), then loads the result; it takes no new job
// until that result is loaded, which sets the sustained rate.
// A two-entry queue sits between front and back; a stalled receiver holds the
// result register, then the back end, then the queue fills and full rises.
// Reset clears counters, window and queue; configuration returns to 640x480,
// divisor 1 and each kernel row 0, 1, 0. The line store needs no clearing.
module rgb_3x3_convolution_clamp_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rgbc_pkg::pixel_t  pixel_in,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output rgbc_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [47:0]       cfg_data
);
	import rgbc_pkg::*;

	geom_t geom_q;
	coef_t coef_q;
	logic  q_full, q_empty, q_pop, job_push;
	job_t  job, q_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.width     <= WID_W'(640);
			geom_q.height    <= HGT_W'(480);
			coef_q.divisor   <= DIV_W'(1);
			coef_q.kernel[0] <= KROW_W'(65536);
			coef_q.kernel[1] <= KROW_W'(65536);
			coef_q.kernel[2] <= KROW_W'(65536);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:   geom_q.width     <= cfg_data[WID_W-1:0];
				REG_HEIGHT:  geom_q.height    <= cfg_data[HGT_W-1:0];
				REG_DIVISOR: coef_q.divisor   <= cfg_data[DIV_W-1:0];
				REG_KTOP:    coef_q.kernel[0] <= cfg_data;
				REG_KMID:    coef_q.kernel[1] <= cfg_data;
				REG_KBOT:    coef_q.kernel[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rgbc_front u_front (
		.clk(clk), .arst_n(arst_n), .geom(geom_q), .push(push), .pixel_in(pixel_in),
		.full(full), .q_full(q_full), .job_push(job_push), .job(job)
	);

	rgbc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(job_push), .din(job), .pop(q_pop),
		.full(q_full), .empty(q_empty), .dout(q_job)
	);

	rgbc_back u_back (
		.clk(clk), .arst_n(arst_n), .coefs(coef_q), .q_empty(q_empty), .q_job(q_job),
		.q_pop(q_pop), .empty(empty), .pop(pop), .result(result)
	);

endmodule

### verif/tb_rgb_3x3_convolution_clamp_top.sv
module tb_rgb_3x3_convolution_clamp_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rgbc_pkg::*;

	localparam int CYCLE_LIMIT  = 800000;
	localparam int RANDOM_ITEMS = 260;
	localparam int SETTLE       = 60;

	logic    clk;
	logic    arst_n;
	logic    push;
	pixel_t  pixel_in;
	logic    full;
	logic    empty;
	logic    pop;
	result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;

	rgb_3x3_convolution_clamp_top uut (
		.clk(clk), .arst_n(arst_n), .push(push), .pixel_in(pixel_in), .full(full),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow configuration and filter state
	logic [WID_W-1:0]  img_w;
	logic [HGT_W-1:0]  img_h;
	logic [DIV_W-1:0]  div_reg;
	logic [KROW_W-1:0] krow [3];
	logic [23:0]       lines [2][MAX_WIDTH];
	logic [23:0]       win [3][3];
	int                row_pos, col_pos;

	result_t filtered_q [$];
	int      errors, pixels_sent, results_seen, cycles;
	bit      steady;
	logic    stall_req;
	int      stall_left;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout, %0d results still due", $time, filtered_q.size());
			$display("rgb_3x3_convolution_clamp_top regression: fail");
			$finish;
		end
	end

	// receiver hold-off counter
	always @(posedge clk) begin
		if (stall_req)
			stall_left <= 1500;
		else if (stall_left > 0)
			stall_left <= stall_left - 1;
	end

	function automatic logic [7:0] convolve_plane(int sh, longint dv);
		longint acc;
		acc = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				acc += longint'(win[i][j][sh +: 8]) * longint'($signed(krow[i][16*j +: 16]));
		acc = acc / dv;
		if (acc < 0) acc = 0;
		if (acc > PIX_MAX) acc = PIX_MAX;
		return acc[7:0];
	endfunction

	task automatic convolve_pixel(pixel_t p);
		int w, h, r, c;
		longint dv;
		logic [23:0] px, top, mid;
		result_t res;
		w = (img_w < 3) ? 3 : (img_w > MAX_WIDTH) ? MAX_WIDTH : int'(img_w);
		h = (img_h < 3) ? 3 : (img_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(img_h);
		dv = (div_reg == 0) ? 1 : longint'(div_reg);
		if (p.frame_start) begin
			row_pos = 0;
			col_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		px = {p.blue_in, p.green_in, p.red_in};
		top = lines[0][c];
		mid = lines[1][c];
		lines[0][c] = mid;
		lines[1][c] = px;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = px;
		if (r >= 2 && c >= 2 && r < h && c < w) begin
			res.red_out    = convolve_plane(0, dv);
			res.green_out  = convolve_plane(8, dv);
			res.blue_out   = convolve_plane(16, dv);
			res.centre_row = ROW_W'(r - 1);
			res.centre_col = COL_W'(c - 1);
			res.frame_done = (r == h - 1 && c == w - 1);
			filtered_q.push_back(res);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		row_pos = r;
		col_pos = c;
	endtask

	task automatic report(string field, int want, int got);
		$display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (filtered_q.size() == 0) begin
				$display("%0t unexpected result, expected none, actual %p", $time, result);
				errors++;
			end else begin
				want = filtered_q.pop_front();
				if (result.red_out !== want.red_out)
					report("red_out", want.red_out, result.red_out);
				if (result.green_out !== want.green_out)
					report("green_out", want.green_out, result.green_out);
				if (result.blue_out !== want.blue_out)
					report("blue_out", want.blue_out, result.blue_out);
				if (result.centre_row !== want.centre_row)
					report("centre_row", want.centre_row, result.centre_row);
				if (result.centre_col !== want.centre_col)
					report("centre_col", want.centre_col, result.centre_col);
				if (result.frame_done !== want.frame_done)
					report("frame_done", want.frame_done, result.frame_done);
			end
		end
		pop <= (stall_left == 0) && (steady || $urandom_range(99) >= 23);
	end

	task automatic send_pixel(pixel_t p);
		if (!steady && $urandom_range(99) < 23) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		pixel_in <= p;
		@(posedge clk);
		while (full) @(posedge clk);
		pixels_sent++;
		convolve_pixel(p);
	endtask

	// stop sending, wait for every result, then let the back end go quiet
	task automatic drain;
		push <= 1'b0;
		@(posedge clk);
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WIDTH:   img_w   = val[WID_W-1:0];
			REG_HEIGHT:  img_h   = val[HGT_W-1:0];
			REG_DIVISOR: div_reg = val[DIV_W-1:0];
			REG_KTOP:    krow[0] = val;
			REG_KMID:    krow[1] = val;
			REG_KBOT:    krow[2] = val;
			default: ;
		endcase
	endtask

	task automatic configure(int w, int h, int dv, logic [47:0] k0, k1, k2);
		drain();
		write_reg(REG_WIDTH, 48'(w));
		write_reg(REG_HEIGHT, 48'(h));
		write_reg(REG_DIVISOR, 48'(dv));
		write_reg(REG_KTOP, k0);
		write_reg(REG_KMID, k1);
		write_reg(REG_KBOT, k2);
	endtask

	function automatic pixel_t rand_pixel(int fs_pct);
		pixel_t p;
		p.red_in      = $urandom_range(255);
		p.green_in    = $urandom_range(255);
		p.blue_in     = $urandom_range(255);
		p.frame_start = ($urandom_range(99) < fs_pct);
		return p;
	endfunction

	function automatic logic [47:0] rand_krow(bit wide);
		logic [47:0] k;
		for (int j = 0; j < 3; j++)
			k[16*j +: 16] = wide ? 16'($urandom) : 16'($urandom_range(64) - 32);
		return k;
	endfunction

	task automatic send_frame(int n, bit first_start);
		pixel_t p;
		for (int i = 0; i < n; i++) begin
			p = rand_pixel(0);
			p.frame_start = first_start && (i == 0);
			send_pixel(p);
		end
	endtask

	// 3x3 frames of extreme samples under saturating kernels, clamped dims, zero divisor
	task automatic test_extremes;
		pixel_t p;
		configure(2, 1, 0, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_8000_7FFF);
		for (int pass = 0; pass < 2; pass++) begin
			for (int k = 0; k < 9; k++) begin
				p.red_in      = (k % 2) ? 8'hFF : 8'h00;
				p.green_in    = ~p.red_in;
				p.blue_in     = 8'(k * 31);
				p.frame_start = (k == 0);
				send_pixel(p);
			end
			configure(3, 3, 65535, 48'h8000_8000_8000, 48'h8000_7FFF_8000,
			          48'h8000_8000_8000);
		end
		// frame_start in the middle of a row, then a plain frame under kernel rows 0, 1, 0
		configure(3, 3, 1, 48'h0001_0000, 48'h0001_0000, 48'h0001_0000);
		send_frame(4, 1'b1);
		send_frame(9, 1'b1);
	endtask

	// width above the line store saturates to the maximum; height at its extreme
	task automatic test_dimension_limits;
		configure(2047, 3, 3, rand_krow(0), rand_krow(0), rand_krow(0));
		send_frame(MAX_WIDTH + 40, 1'b1);
		// narrow the row mid-frame: the next row's results show where the wide row ended
		configure(3, 3, 3, krow[0], krow[1], krow[2]);
		send_frame(6, 1'b0);
		configure(3, 8191, 1, rand_krow(0), rand_krow(0), rand_krow(0));
		send_frame(60, 1'b1);
	endtask

	// shrink width and height while the counters sit beyond the new size
	task automatic test_shrink_midframe;
		configure(10, 10, 2, rand_krow(0), rand_krow(0), rand_krow(0));
		send_frame(45, 1'b1);
		configure(4, 3, 2, krow[0], krow[1], krow[2]);
		send_frame(40, 1'b0);
	endtask

	// receiver holds off while pixels keep coming, so full must rise
	task automatic test_backpressure;
		configure(4, 4, 1, rand_krow(0), rand_krow(0), rand_krow(0));
		stall_req <= 1'b1;
		@(posedge clk);
		stall_req <= 1'b0;
		send_frame(48, 1'b1);
		drain();
		steady = 1'b1;
		send_frame(80, 1'b0);
		steady = 1'b0;
	endtask

	task automatic test_random;
		int target, w, h, dv;
		bit wide;
		target = pixels_sent + RANDOM_ITEMS;
		while (pixels_sent < target) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(3, 9);
			h = $urandom_range(2, 8);
			wide = ($urandom_range(3) == 0);
			case ($urandom_range(5))
				0: dv = 0;
				1: dv = $urandom_range(65535);
				default: dv = $urandom_range(1, 16);
			endcase
			configure(w, h, dv, rand_krow(wide), rand_krow(wide), rand_krow(wide));
			send_pixel(rand_pixel(100));
			repeat ($urandom_range(40, 120)) send_pixel(rand_pixel(3));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		pixel_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stall_req = 1'b0;
		stall_left = 0;
		steady = 1'b0;
		errors = 0;
		pixels_sent = 0;
		results_seen = 0;
		cycles = 0;
		img_w = 640;
		img_h = 480;
		div_reg = 1;
		for (int i = 0; i < 3; i++) krow[i] = 48'h1_0000;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) win[i][j] = '0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			lines[0][i] = '0;
			lines[1][i] = '0;
		end
		row_pos = 0;
		col_pos = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_dimension_limits();
		test_shrink_midframe();
		test_backpressure();
		test_random();
		drain();

		$display("covered extremes, clamped dimensions, mid-frame resize, back-pressure");
		$display("%0d pixels in, %0d filtered results checked", pixels_sent, results_seen);
		if (errors == 0)
			$display("rgb_3x3_convolution_clamp_top regression: pass");
		else
			$display("rgb_3x3_convolution_clamp_top regression: fail");
		$finish;
	end
endmodule
